/* src/it8254_pkg.sv */
package it8254_pkg;

  localparam int MAX_CHANNELS = 3;
  localparam int DEF_NUM_CHANNELS = 3;
  localparam int CNT_W = 17;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_GATE  = 2'd3
  } kind_t;

  localparam logic [1:0] PORT_CTRL = 2'd3;

  typedef struct packed {
    logic thit;
    logic en;
    logic gate;
    logic init;
    logic newc;
    logic dis;
    logic latched;
    logic reread;
    logic stat;
    logic outp;
  } flags_t;

  typedef struct packed {
    logic [15:0]      reload;
    logic [CNT_W-1:0] count;
    logic [2:0]       mode;
    logic [7:0]       ctrl;
    logic [1:0]       rphase;
    logic [1:0]       wphase;
    logic [CNT_W-1:0] olatch;
    logic [7:0]       slatch;
    flags_t           flags;
  } chan_t;

  // Decoded item broadcast to every counter.
  typedef struct packed {
    logic       tick;
    logic       wr_cnt;
    logic       rd_cnt;
    logic       gate;
    logic       ctrl;
    logic [1:0] sel;
    logic [7:0] data;
    logic       level;
  } op_t;

  function automatic logic [CNT_W-1:0] eff_reload(input logic [15:0] r);
    return (r == 16'd0) ? 17'h10000 : {1'b0, r};
  endfunction

  function automatic logic [CNT_W-1:0] sq_half(input logic [15:0] r, input logic high);
    logic [CNT_W-1:0] l;
    l = eff_reload(r);
    if (!l[0]) return l;
    if (high) return l + 17'd1;
    return (l > 17'd1) ? l - 17'd1 : 17'd2;
  endfunction

  function automatic logic [CNT_W-1:0] read_count(input chan_t c);
    return (c.mode == 3'd2) ? c.count + 17'd1 : c.count;
  endfunction

endpackage

/* src/it8254_chan.sv */
module it8254_chan #(
  parameter logic [1:0] IDX = 2'd0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_valid,
  input  it8254_pkg::op_t     op,
  output it8254_pkg::chan_t   st,
  output logic [7:0]          rd_byte
);
  import it8254_pkg::*;

  chan_t st_r, st_nxt;
  chan_t st_rst;

  // present the state as it stands after the current item
  assign st = st_nxt;

  always_comb begin
    st_rst = '0;
    st_rst.reload = 16'hffff;
    st_rst.flags.thit = 1'b1;
    st_rst.flags.gate = (IDX != 2'd2);
  end

  always_comb begin
    chan_t c;
    logic [CNT_W-1:0] l, cnt;
    logic [2:0] m;
    logic rise;
    logic [7:0] v;
    c = st_r;
    rd_byte = 8'hff;
    l = eff_reload(c.reload);
    v = op.data;
    m = 3'd0;
    rise = 1'b0;
    cnt = '0;
    if (op_valid) begin
      if (op.tick && op.sel == IDX) begin
        if (!c.flags.thit && c.flags.en) begin
          c.count = c.count - ((c.mode == 3'd3) ? 17'd2 : 17'd1);
          if (c.count == '0) begin
            cnt = c.count;
            if (c.flags.dis) begin
              cnt = cnt + 17'h0ffff;
            end else begin
              unique case (c.mode)
                3'd0, 3'd1, 3'd5: begin
                  c.flags.outp = 1'b1;
                  c.flags.thit = 1'b1;
                  cnt = cnt + 17'h0ffff;
                end
                3'd2: begin
                  cnt = cnt + l;
                  c.flags.outp = 1'b1;
                end
                3'd3: begin
                  cnt = cnt + sq_half(c.reload, !c.flags.outp);
                  c.flags.outp = !c.flags.outp;
                end
                default: begin
                  if (!c.flags.thit) c.flags.outp = 1'b1;
                  if (c.flags.newc) begin
                    c.flags.newc = 1'b0;
                    cnt = cnt + l;
                  end else begin
                    c.flags.thit = 1'b1;
                    cnt = cnt + 17'h0ffff;
                  end
                end
              endcase
            end
            c.count = cnt;
          end
        end
      end
      if (op.gate && op.sel == IDX) begin
        rise = op.level && !c.flags.gate;
        if (!c.flags.dis) begin
          unique case (c.mode)
            3'd0, 3'd4: c.flags.en = op.level;
            3'd1, 3'd5: begin
              if (rise) begin
                c.count = l;
                c.flags.outp = 1'b0;
                c.flags.thit = 1'b0;
                c.flags.en = 1'b1;
              end
            end
            3'd2: begin
              if (rise) begin
                c.count = l - 17'd1;
                c.flags.outp = 1'b1;
                c.flags.thit = 1'b0;
              end
              c.flags.en = op.level;
            end
            default: begin
              if (rise) begin
                c.count = sq_half(c.reload, 1'b1);
                c.flags.outp = 1'b1;
                c.flags.thit = 1'b0;
              end
              c.flags.en = op.level;
            end
          endcase
        end
        c.flags.gate = op.level;
      end
      if (op.ctrl) begin
        if (v[7:6] == 2'b11) begin
          if (v[3'd1 + 3'(IDX)]) begin
            if (!v[5]) c.olatch = read_count(c);
            if (!v[4]) begin
              c.slatch = {c.flags.outp, 1'b0, c.ctrl[5:0]};
              c.flags.stat = 1'b1;
            end
          end
        end else if (v[7:6] == IDX) begin
          if (v[5:4] == 2'b00) begin
            c.olatch = read_count(c);
            c.flags.reread = 1'b0;
            c.rphase = 2'd3;
            c.flags.latched = 1'b1;
          end else begin
            m = v[3:1];
            if (m > 3'd5) m = {1'b0, m[1:0]};
            c.ctrl = v;
            c.rphase = v[5:4];
            c.wphase = v[5:4];
            c.mode = m;
            c.flags.reread = 1'b1;
            c.flags.init = 1'b1;
            c.flags.outp = (m != 3'd0);
            c.flags.dis = 1'b1;
          end
          c.flags.thit = 1'b0;
        end
      end
      if (op.wr_cnt && op.sel == IDX) begin
        unique case (c.wphase)
          2'd0: begin
            c.reload = {v, c.reload[7:0]};
            c.wphase = 2'd3;
          end
          2'd1: c.reload = {8'd0, v};
          2'd2: c.reload = {v, 8'd0};
          default: begin
            c.reload = {c.reload[15:8], v};
            c.wphase = 2'd0;
          end
        endcase
        if (st_r.wphase != 2'd3) begin
          // load the new count
          l = eff_reload(c.reload);
          c.flags.newc = 1'b0;
          c.flags.dis = 1'b0;
          unique case (c.mode)
            3'd0: begin
              c.count = l;
              c.flags.outp = 1'b0;
              c.flags.thit = 1'b0;
              c.flags.en = c.flags.gate;
            end
            3'd2: begin
              if (c.flags.init) begin
                c.count = l - 17'd1;
                c.flags.outp = 1'b1;
                c.flags.thit = 1'b0;
              end
              c.flags.en = c.flags.gate;
            end
            3'd3: begin
              if (c.flags.init) begin
                c.count = sq_half(c.reload, 1'b1);
                c.flags.outp = 1'b1;
                c.flags.thit = 1'b0;
              end
              c.flags.en = c.flags.gate;
            end
            3'd4: begin
              if (!c.flags.thit && !c.flags.init) begin
                c.flags.newc = 1'b1;
              end else begin
                c.count = l;
                c.flags.outp = 1'b0;
                c.flags.thit = 1'b0;
              end
              c.flags.en = c.flags.gate;
            end
            default: c.flags.en = 1'b1;
          endcase
          c.flags.init = 1'b0;
        end
      end
      if (op.rd_cnt && op.sel == IDX) begin
        if (c.flags.stat) begin
          c.flags.stat = 1'b0;
          rd_byte = c.slatch;
        end else begin
          if (c.flags.reread && !c.flags.latched) begin
            c.flags.reread = 1'b0;
            c.olatch = read_count(c);
          end
          unique case (c.rphase)
            2'd0: begin
              rd_byte = c.olatch[15:8];
              c.rphase = 2'd3;
              c.flags.latched = 1'b0;
              c.flags.reread = 1'b1;
            end
            2'd1: begin
              rd_byte = c.olatch[7:0];
              c.flags.latched = 1'b0;
              c.flags.reread = 1'b1;
            end
            2'd2: begin
              rd_byte = c.olatch[15:8];
              c.flags.latched = 1'b0;
              c.flags.reread = 1'b1;
            end
            default: begin
              rd_byte = c.olatch[7:0];
              c.rphase = 2'd0;
            end
          endcase
        end
      end
    end
    st_nxt = c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

/* src/interval_timer_8254_unit.sv */
// Three-counter interval timer, 8254 style, driven one item per beat.
// Input channel (in_valid/in_ready): in_mode selects clock tick, bus write,
// bus read or gate change; in_port addresses counters 0..2 or the control
// register; in_channel picks the counter for a tick or gate change.
// Output channel (out_valid/out_ready): one result beat per input beat,
// carrying out_read_data (255 unless a read) and the three output levels
// as they stand after the item.
// Path: the item is decoded into an input register; once the result register
// is free, the item is applied to the counter state and its result is
// registered at the same time.
// Throughput: one item per cycle while the receiver takes the results; the
// counter update is a single pass of logic between the input register and the counter/result registers.
// Reset (rst_n low, synchronous) returns every counter to its power-on
// state and empties both stages. When the receiver stalls, the result
// register and then the input register hold; in_ready falls only once
// both are full.
module interval_timer_8254_unit #(
  parameter int NUM_CHANNELS = it8254_pkg::DEF_NUM_CHANNELS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [1:0] in_port,
  input  logic [7:0] in_write_data,
  input  logic [1:0] in_channel,
  input  logic       in_gate_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_out_zero,
  output logic       out_out_one,
  output logic       out_out_two
);
  import it8254_pkg::*;

  logic op_v_r, op_v_nxt;
  op_t  op_r, op_nxt;
  logic res_v_r, res_v_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic [2:0] lvl_r, lvl_nxt;
  logic advance;
  logic [7:0] rd_ch [MAX_CHANNELS];
  chan_t st_ch [MAX_CHANNELS];
  logic [2:0] lvl_now;
  logic [7:0] ctl_r, ctl_nxt;
  kind_t kind;

  assign advance = op_v_r && (!res_v_r || out_ready);
  assign in_ready = !op_v_r || advance;
  assign kind = kind_t'(in_mode);

  always_comb begin
    op_nxt = '0;
    op_nxt.sel = (kind == KIND_TICK || kind == KIND_GATE) ? in_channel : in_port;
    op_nxt.data = in_write_data;
    op_nxt.level = in_gate_level;
    unique case (kind)
      KIND_TICK:  op_nxt.tick = 1'b1;
      KIND_WRITE: begin
        op_nxt.ctrl   = (in_port == PORT_CTRL);
        op_nxt.wr_cnt = (in_port != PORT_CTRL);
      end
      KIND_READ:  op_nxt.rd_cnt = 1'b1;
      default:    op_nxt.gate = 1'b1;
    endcase
    op_v_nxt = (in_valid && in_ready) || (op_v_r && !advance);
  end

  genvar g;
  generate
    for (g = 0; g < MAX_CHANNELS; g++) begin : g_ch
      if (g < NUM_CHANNELS) begin : g_on
        it8254_chan #(.IDX(2'(g))) u_chan (
          .clk(clk), .rst_n(rst_n), .op_valid(advance), .op(op_r),
          .st(st_ch[g]), .rd_byte(rd_ch[g])
        );
        assign lvl_now[g] = st_ch[g].flags.outp;
      end else begin : g_off
        assign st_ch[g] = '0;
        assign rd_ch[g] = 8'hff;
        assign lvl_now[g] = 1'b0;
      end
    end
  endgenerate

  // Capture the read byte, the levels after the item and the control word for read-back.
  always_comb begin
    rd_nxt = rd_r;
    lvl_nxt = lvl_r;
    ctl_nxt = ctl_r;
    res_v_nxt = res_v_r && !out_ready;
    if (advance) begin
      res_v_nxt = 1'b1;
      rd_nxt = 8'hff;
      lvl_nxt = lvl_now;
      if (op_r.rd_cnt) begin
        if (op_r.sel == PORT_CTRL) rd_nxt = ctl_r;
        else if (32'(op_r.sel) < NUM_CHANNELS) rd_nxt = rd_ch[op_r.sel];
      end
      if (op_r.ctrl && op_r.data[7:6] != 2'b11) begin
        ctl_nxt = (op_r.data[5:4] == 2'b00 && 32'(op_r.data[7:6]) < NUM_CHANNELS) ?
                  (op_r.data | 8'h30) : op_r.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_v_r <= 1'b0;
      res_v_r <= 1'b0;
      ctl_r <= 8'd0;
    end else begin
      op_v_r <= op_v_nxt;
      res_v_r <= res_v_nxt;
      ctl_r <= ctl_nxt;
    end
    if (in_valid && in_ready) op_r <= op_nxt;
    rd_r <= rd_nxt;
    lvl_r <= lvl_nxt;
  end

  assign out_valid = res_v_r;
  assign out_read_data = rd_r;
  assign out_out_zero = lvl_r[0];
  assign out_out_one  = lvl_r[1];
  assign out_out_two  = lvl_r[2];

  assert property (@(posedge clk) disable iff (!rst_n) advance |=> res_v_r)
    else $error("applied item lost its result");
  assert property (@(posedge clk) disable iff (!rst_n) !op_v_r |-> in_ready)
    else $error("empty input stage refused a beat");
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_v_r && !out_ready && !advance) |=> $stable(rd_r))
    else $error("stalled result changed");

endmodule

/* test/interval_timer_8254_unit_tb.sv */
module interval_timer_8254_unit_tb;
  import it8254_pkg::*;

  localparam int NCH = 3;

  class timer_scoreboard;
    logic [15:0] reload[3];
    logic [16:0] count[3];
    logic [2:0]  cmode[3];
    logic [7:0]  ctrl[3];
    logic [1:0]  rph[3];
    logic [1:0]  wph[3];
    logic [16:0] olat[3];
    logic [7:0]  slat[3];
    flags_t      fl[3];
    logic [7:0]  lastc;
    logic [10:0] pending[$];
    int          errors;
    int          shown;

    function void clear();
      for (int c = 0; c < 3; c++) begin
        reload[c] = 16'hffff;
        count[c] = '0;
        cmode[c] = '0;
        ctrl[c] = '0;
        rph[c] = '0;
        wph[c] = '0;
        olat[c] = '0;
        slat[c] = '0;
        fl[c] = '0;
        fl[c].thit = 1'b1;
        fl[c].gate = (c != 2);
      end
      lastc = '0;
      pending.delete();
      errors = 0;
      shown = 0;
    endfunction

    function logic [16:0] full_load(int c);
      return (reload[c] == 16'd0) ? 17'h10000 : {1'b0, reload[c]};
    endfunction

    function logic [16:0] half_period(int c, bit hi);
      logic [16:0] l;
      l = full_load(c);
      if (!l[0]) return l;
      if (hi) return l + 17'd1;
      return (l > 17'd1) ? l - 17'd1 : 17'd2;
    endfunction

    function logic [16:0] live_count(int c);
      return (cmode[c] == 3'd2) ? count[c] + 17'd1 : count[c];
    endfunction

    function void reach_zero(int c);
      logic [16:0] n;
      n = count[c];
      if (fl[c].dis) begin
        count[c] = n + 17'hffff;
        return;
      end
      case (cmode[c])
        3'd0, 3'd1, 3'd5: begin
          fl[c].outp = 1'b1;
          fl[c].thit = 1'b1;
          n = n + 17'hffff;
        end
        3'd2: begin
          n = n + full_load(c);
          fl[c].outp = 1'b1;
        end
        3'd3: begin
          if (fl[c].outp) begin
            fl[c].outp = 1'b0;
            n = n + half_period(c, 0);
          end else begin
            fl[c].outp = 1'b1;
            n = n + half_period(c, 1);
          end
        end
        default: begin
          if (!fl[c].thit) fl[c].outp = 1'b1;
          if (fl[c].newc) begin
            fl[c].newc = 1'b0;
            n = n + full_load(c);
          end else begin
            fl[c].thit = 1'b1;
            n = n + 17'hffff;
          end
        end
      endcase
      count[c] = n;
    endfunction

    function void start_count(int c);
      logic [16:0] l;
      bit ini, g;
      l = full_load(c);
      ini = fl[c].init;
      g = fl[c].gate;
      fl[c].newc = 1'b0;
      fl[c].dis = 1'b0;
      case (cmode[c])
        3'd0: begin
          count[c] = l;
          fl[c].outp = 1'b0;
          fl[c].thit = 1'b0;
          fl[c].en = g;
        end
        3'd2: begin
          if (ini) begin
            count[c] = l - 17'd1;
            fl[c].outp = 1'b1;
            fl[c].thit = 1'b0;
          end
          fl[c].en = g;
        end
        3'd3: begin
          if (ini) begin
            count[c] = half_period(c, 1);
            fl[c].outp = 1'b1;
            fl[c].thit = 1'b0;
          end
          fl[c].en = g;
        end
        3'd4: begin
          if (!fl[c].thit && !ini) fl[c].newc = 1'b1;
          else begin
            count[c] = l;
            fl[c].outp = 1'b0;
            fl[c].thit = 1'b0;
          end
          fl[c].en = g;
        end
        default: fl[c].en = 1'b1;
      endcase
      fl[c].init = 1'b0;
    endfunction

    function void clock_tick(int c);
      if (fl[c].thit || !fl[c].en) return;
      count[c] = count[c] - ((cmode[c] == 3'd3) ? 17'd2 : 17'd1);
      if (count[c] == 17'd0) reach_zero(c);
    endfunction

    function void gate_move(int c, bit g);
      logic [16:0] l;
      bit rise;
      l = full_load(c);
      rise = g && !fl[c].gate;
      if (!fl[c].dis) begin
        case (cmode[c])
          3'd0, 3'd4: fl[c].en = g;
          3'd1, 3'd5: if (rise) begin
            count[c] = l;
            fl[c].outp = 1'b0;
            fl[c].thit = 1'b0;
            fl[c].en = 1'b1;
          end
          3'd2: begin
            if (rise) begin
              count[c] = l - 17'd1;
              fl[c].outp = 1'b1;
              fl[c].thit = 1'b0;
            end
            fl[c].en = g;
          end
          default: begin
            if (rise) begin
              count[c] = half_period(c, 1);
              fl[c].outp = 1'b1;
              fl[c].thit = 1'b0;
            end
            fl[c].en = g;
          end
        endcase
      end
      fl[c].gate = g;
    endfunction

    function void control_write(logic [7:0] v);
      int c;
      logic [2:0] m;
      if (v[7:6] == 2'b11) begin
        for (int k = 0; k < NCH; k++) begin
          if (!v[k+1]) continue;
          if (!v[5]) olat[k] = live_count(k);
          if (!v[4]) begin
            slat[k] = {fl[k].outp, 1'b0, ctrl[k][5:0]};
            fl[k].stat = 1'b1;
          end
        end
        return;
      end
      c = v[7:6];
      lastc = v;
      if (c >= NCH) return;
      if (v[5:4] == 2'b00) begin
        olat[c] = live_count(c);
        lastc = v | 8'h30;
        fl[c].reread = 1'b0;
        rph[c] = 2'd3;
        fl[c].latched = 1'b1;
      end else begin
        m = v[3:1];
        if (m > 3'd5) m = m & 3'd3;
        ctrl[c] = v;
        rph[c] = v[5:4];
        wph[c] = v[5:4];
        cmode[c] = m;
        fl[c].reread = 1'b1;
        fl[c].init = 1'b1;
        fl[c].outp = (m != 3'd0);
        fl[c].dis = 1'b1;
      end
      fl[c].thit = 1'b0;
    endfunction

    function void counter_write(int c, logic [7:0] v);
      case (wph[c])
        2'd0: begin
          reload[c] = {v, reload[c][7:0]};
          start_count(c);
          wph[c] = 2'd3;
        end
        2'd1: begin
          reload[c] = {8'd0, v};
          start_count(c);
        end
        2'd2: begin
          reload[c] = {v, 8'd0};
          start_count(c);
        end
        default: begin
          reload[c] = {reload[c][15:8], v};
          wph[c] = 2'd0;
        end
      endcase
    endfunction

    function logic [7:0] counter_read(int c);
      logic [7:0] r;
      if (fl[c].stat) begin
        fl[c].stat = 1'b0;
        return slat[c];
      end
      if (fl[c].reread && !fl[c].latched) begin
        fl[c].reread = 1'b0;
        olat[c] = live_count(c);
      end
      case (rph[c])
        2'd0: begin
          r = olat[c][15:8];
          rph[c] = 2'd3;
          fl[c].latched = 1'b0;
          fl[c].reread = 1'b1;
        end
        2'd1: begin
          r = olat[c][7:0];
          fl[c].latched = 1'b0;
          fl[c].reread = 1'b1;
        end
        2'd2: begin
          r = olat[c][15:8];
          fl[c].latched = 1'b0;
          fl[c].reread = 1'b1;
        end
        default: begin
          r = olat[c][7:0];
          rph[c] = 2'd0;
        end
      endcase
      return r;
    endfunction

    function void note_item(kind_t k, logic [1:0] p, logic [7:0] d, logic [1:0] ch, bit g);
      logic [7:0] rd;
      rd = 8'hff;
      case (k)
        KIND_TICK: if (ch < NCH) clock_tick(ch);
        KIND_WRITE: begin
          if (p == PORT_CTRL) control_write(d);
          else if (p < NCH) counter_write(p, d);
        end
        KIND_READ: begin
          if (p == PORT_CTRL) rd = lastc;
          else if (p < NCH) rd = counter_read(p);
        end
        default: if (ch < NCH) gate_move(ch, g);
      endcase
      pending.push_back({rd, fl[2].outp, fl[1].outp, fl[0].outp});
    endfunction

    function void check_result(logic [7:0] rd, logic o0, logic o1, logic o2);
      logic [10:0] e;
      if (pending.size() == 0) begin
        errors++;
        if (shown++ < 10) $display("unexpected result beat rd=%0h outs=%b%b%b", rd, o2, o1, o0);
        return;
      end
      e = pending.pop_front();
      if (e !== {rd, o2, o1, o0}) begin
        errors++;
        if (shown++ < 10)
          $display("mismatch: expected rd=%0h outs=%b, got rd=%0h outs=%b%b%b",
                   e[10:3], e[2:0], rd, o2, o1, o0);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic [1:0] in_port = '0;
  logic [7:0] in_write_data = '0;
  logic [1:0] in_channel = '0;
  logic in_gate_level = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic out_out_zero, out_out_one, out_out_two;

  timer_scoreboard sb;
  bit feed_done = 1'b0;
  bit hold_off = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  interval_timer_8254_unit i_dut (.*);

  // drop valid only across an idle gap, so back-to-back beats keep it high
  task automatic send_beat(kind_t k, logic [1:0] p, logic [7:0] d, logic [1:0] ch, bit g);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= k;
    in_port <= p;
    in_write_data <= d;
    in_channel <= ch;
    in_gate_level <= g;
    do @(posedge clk); while (!in_ready);
    sb.note_item(k, p, d, ch, g);
  endtask

  // program a counter: control word then the bytes its access mode needs
  task automatic program_counter(int c, logic [2:0] m, logic [1:0] acc, logic [15:0] v);
    send_beat(KIND_WRITE, PORT_CTRL, {c[1:0], acc, m, 1'b0}, 2'd0, 1'b0);
    if (acc != 2'd2) send_beat(KIND_WRITE, c[1:0], v[7:0], 2'd0, 1'b0);
    if (acc != 2'd1) send_beat(KIND_WRITE, c[1:0], v[15:8], 2'd0, 1'b0);
  endtask

  task automatic random_beat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      send_beat(KIND_TICK, 2'($urandom), 8'($urandom), 2'($urandom_range(0, 2)), 1'($urandom));
    else if (r < 60)
      send_beat(KIND_TICK, 2'($urandom), 8'($urandom), 2'd3, 1'($urandom));
    else if (r < 70)
      send_beat(KIND_READ, 2'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
    else if (r < 78)
      send_beat(KIND_GATE, 2'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
    else if (r < 84)
      send_beat(KIND_WRITE, 2'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
    else if (r < 88)
      send_beat(KIND_WRITE, PORT_CTRL, {2'b11, 6'($urandom)}, 2'($urandom), 1'($urandom));
    else begin
      // mostly short counts so terminal count is actually reached
      program_counter($urandom_range(0, 2), 3'($urandom), 2'($urandom_range(1, 3)),
                      ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9)));
      if ($urandom_range(0, 1)) send_beat(KIND_GATE, 2'd0, 8'd0, 2'($urandom_range(0, 2)), 1'b1);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: modes 0, 3, 4 and 5, every access kind, latch, read-back, absent channel
    send_beat(KIND_READ, PORT_CTRL, 8'd0, 2'd0, 1'b0);
    send_beat(KIND_GATE, 2'd0, 8'd0, 2'd2, 1'b1);
    program_counter(0, 3'd0, 2'd3, 16'd3);
    repeat (4) send_beat(KIND_TICK, 2'd0, 8'd0, 2'd0, 1'b0);
    program_counter(1, 3'd3, 2'd1, 16'd1);
    repeat (3) send_beat(KIND_TICK, 2'd0, 8'd0, 2'd1, 1'b0);
    program_counter(2, 3'd7, 2'd2, 16'd0);
    send_beat(KIND_TICK, 2'd0, 8'd0, 2'd3, 1'b1);
    send_beat(KIND_WRITE, PORT_CTRL, 8'h00, 2'd0, 1'b0);
    send_beat(KIND_READ, 2'd0, 8'd0, 2'd0, 1'b0);
    send_beat(KIND_READ, 2'd0, 8'd0, 2'd0, 1'b0);
    send_beat(KIND_WRITE, PORT_CTRL, 8'hce, 2'd0, 1'b0);
    send_beat(KIND_READ, 2'd1, 8'd0, 2'd0, 1'b0);
    send_beat(KIND_READ, PORT_CTRL, 8'd0, 2'd0, 1'b0);
    send_beat(KIND_WRITE, 2'd2, 8'hff, 2'd0, 1'b0);
    program_counter(0, 3'd4, 2'd3, 16'hffff);
    program_counter(1, 3'd5, 2'd3, 16'd2);
    send_beat(KIND_GATE, 2'd0, 8'd0, 2'd1, 1'b0);
    send_beat(KIND_GATE, 2'd0, 8'd0, 2'd1, 1'b1);
    for (int n = 0; n < 2000; n++) begin
      if (n == 600) hold_off = 1'b1;
      random_beat();
    end
    in_valid <= 1'b0;
    feed_done = 1'b1;
  end

  initial begin
    bit stall;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
      end
      stall = ($urandom_range(0, 2) != 0);
      if (stall) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_read_data, out_out_zero, out_out_one, out_out_two);
  end

  initial begin
    wait (feed_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
